@@ design/sfvt_pkg.sv @@
package sfvt_pkg;

   localparam int SFVT_PROPERTIES  = 64;
   localparam int SFVT_ENTRIES     = 8;
   localparam int SFVT_STATE_BITS  = 13;
   localparam int SFVT_HANDLE_BITS = 16;

   typedef enum logic [1:0] {
      MODE_SET   = 2'd0,
      MODE_UNSET = 2'd1,
      MODE_MATCH = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // row update decision handed from the update logic to the controller
   typedef struct packed {
      logic       wr_en;
      status_type status;
   } upd_ctl_type;

endpackage

@@ design/state_flag_value_table.sv @@
// A word is taken only in idle: its row is read, then compared and written back, and its
// result word is registered once the output register is free; then the next word is taken.
// Clear all rows: sweeps the row memory, one row per cycle, then answers.
// Reset: synchronous, active high; a sweep zeroes every row count while req_ready stays
// low. Entry contents are zeroed too, as the sweep writes whole rows.
module state_flag_value_table
   import sfvt_pkg::*;
#(
   parameter int PROPERTIES  = SFVT_PROPERTIES,
   parameter int ENTRIES     = SFVT_ENTRIES,
   parameter int STATE_BITS  = SFVT_STATE_BITS,
   parameter int HANDLE_BITS = SFVT_HANDLE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [5:0]  req_property_req,
   input  logic [12:0] req_state_flags,
   input  logic [15:0] req_value_handle,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_value_out,
   output logic [3:0]  rsp_entries_used
);

   localparam int ADDR_W  = (PROPERTIES > 1) ? $clog2(PROPERTIES) : 1;
   localparam int ENTRY_W = STATE_BITS + HANDLE_BITS;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int ROW_W   = CNT_W + ENTRIES * ENTRY_W;

   // one-hot controller states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EXEC  = 3'b010,
      ST_SWEEP = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      sweep_idx_ff, sweep_idx_in;
   logic                   clr_rsp_ff, clr_rsp_in;
   mode_type               mode_ff, mode_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic                   oor_ff, oor_in;
   logic [STATE_BITS-1:0]  key_ff, key_in;
   logic [HANDLE_BITS-1:0] val_ff, val_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             status_ff, status_in;
   logic [15:0]            value_ff, value_in;
   logic [3:0]             used_ff, used_in;

   logic                   accept;
   logic                   out_free;
   logic                   exec_done;
   logic [ADDR_W+5:0]      row_ext;
   logic [STATE_BITS+12:0] key_ext;
   logic [HANDLE_BITS+15:0] val_ext;
   logic [HANDLE_BITS+15:0] vout_ext;
   logic [CNT_W+3:0]       used_ext;

   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   logic [ROW_W-1:0]       mem_wr_data;
   logic [ROW_W-1:0]       mem_rd_data;

   logic [ROW_W-1:0]       upd_row;
   upd_ctl_type            upd_ctl;
   logic [HANDLE_BITS-1:0] upd_value;
   logic [CNT_W-1:0]       upd_used;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // output register is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign exec_done = (state_ff == ST_EXEC) && out_free;

   // fit the fixed-width request fields to the configured widths
   assign row_ext = {{ADDR_W{1'b0}}, req_property_req};
   assign key_ext = {{STATE_BITS{1'b0}}, req_state_flags};
   assign val_ext = {{HANDLE_BITS{1'b0}}, req_value_handle};

   sfvt_row_mem #(
      .DEPTH  (PROPERTIES),
      .ADDR_W (ADDR_W),
      .DATA_W (ROW_W)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (row_ext[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   sfvt_row_update #(
      .ENTRIES     (ENTRIES),
      .STATE_BITS  (STATE_BITS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_row_update (
      .mode         (mode_ff),
      .out_of_range (oor_ff),
      .key          (key_ff),
      .val          (val_ff),
      .row_in       (mem_rd_data),
      .row_out      (upd_row),
      .ctl          (upd_ctl),
      .value_out    (upd_value),
      .used         (upd_used)
   );

   // write port: sweep zeroes a row; otherwise the updated row goes back.
   // Reads are issued only from idle, after this write has landed, so no bypass is needed.
   always_comb begin
      if (state_ff == ST_SWEEP) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = sweep_idx_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = exec_done && upd_ctl.wr_en;
         mem_wr_addr = addr_ff;
         mem_wr_data = upd_row;
      end
   end

   assign vout_ext = {16'b0, upd_value};
   assign used_ext = {4'b0, upd_used};

   // controller
   always_comb begin
      state_in     = state_ff;
      sweep_idx_in = sweep_idx_ff;
      clr_rsp_in   = clr_rsp_ff;
      mode_in      = mode_ff;
      addr_in      = addr_ff;
      oor_in       = oor_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in = mode_type'(req_mode);
               addr_in = row_ext[ADDR_W-1:0];
               oor_in  = (row_ext >= (ADDR_W+6)'(PROPERTIES));
               key_in  = key_ext[STATE_BITS-1:0];
               val_in  = val_ext[HANDLE_BITS-1:0];
               if (mode_type'(req_mode) == MODE_CLEAR) begin
                  state_in     = ST_SWEEP;
                  sweep_idx_in = '0;
                  clr_rsp_in   = 1'b1;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (sweep_idx_ff == ADDR_W'(PROPERTIES - 1)) begin
               // a clear still owes its answer; the reset sweep does not
               state_in   = clr_rsp_ff ? ST_EXEC : ST_IDLE;
               clr_rsp_in = 1'b0;
            end else begin
               sweep_idx_in = sweep_idx_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      used_in      = used_ff;
      if (exec_done) begin
         rsp_valid_in = 1'b1;
         status_in    = upd_ctl.status;
         value_in     = vout_ext[15:0];
         used_in      = used_ext[3:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_idx_ff <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_idx_ff <= sweep_idx_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      addr_ff   <= addr_in;
      oor_ff    <= oor_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      used_ff   <= used_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_value_out    = value_ff;
   assign rsp_entries_used = used_ff;

endmodule

@@ design/sfvt_row_mem.sv @@
module sfvt_row_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 236
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] row_store [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_store[wr_addr] <= wr_data;
      end
   end

   // registered read; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= row_store[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sfvt_row_update.sv @@
module sfvt_row_update
   import sfvt_pkg::*;
#(
   parameter int ENTRIES     = SFVT_ENTRIES,
   parameter int STATE_BITS  = SFVT_STATE_BITS,
   parameter int HANDLE_BITS = SFVT_HANDLE_BITS,
   localparam int ENTRY_W    = STATE_BITS + HANDLE_BITS,
   localparam int CNT_W      = $clog2(ENTRIES + 1),
   localparam int ROW_W      = CNT_W + ENTRIES * ENTRY_W
) (
   input  mode_type               mode,
   input  logic                   out_of_range,
   input  logic [STATE_BITS-1:0]  key,
   input  logic [HANDLE_BITS-1:0] val,
   input  logic [ROW_W-1:0]       row_in,
   output logic [ROW_W-1:0]       row_out,
   output upd_ctl_type            ctl,
   output logic [HANDLE_BITS-1:0] value_out,
   output logic [CNT_W-1:0]       used
);

   logic [CNT_W-1:0]       n;
   logic [STATE_BITS-1:0]  flags  [ENTRIES];
   logic [HANDLE_BITS-1:0] hvals  [ENTRIES];
   logic [STATE_BITS-1:0]  ins_f  [ENTRIES];
   logic [HANDLE_BITS-1:0] ins_h  [ENTRIES];
   logic [STATE_BITS-1:0]  del_f  [ENTRIES];
   logic [HANDLE_BITS-1:0] del_h  [ENTRIES];
   logic [HANDLE_BITS-1:0] rep_h  [ENTRIES];
   logic [ENTRIES-1:0]     lt;
   logic [ENTRIES-1:0]     eq;
   logic [ENTRIES-1:0]     cand;
   logic [ENTRIES-1:0]     above;
   logic [CNT_W-1:0]       pos;
   logic [CNT_W-1:0]       start;
   logic                   hit;
   logic                   full;
   logic                   found;
   logic [HANDLE_BITS-1:0] hit_val;
   logic [HANDLE_BITS-1:0] scan_val;
   logic [ROW_W-1:0]       row_ins;
   logic [ROW_W-1:0]       row_del;
   logic [ROW_W-1:0]       row_rep;

   // unpack and compare every entry against the key
   always_comb begin
      n = row_in[CNT_W-1:0];
      for (int i = 0; i < ENTRIES; i++) begin
         flags[i] = row_in[CNT_W + i*ENTRY_W + HANDLE_BITS +: STATE_BITS];
         hvals[i] = row_in[CNT_W + i*ENTRY_W +: HANDLE_BITS];
         lt[i]    = (CNT_W'(i) < n) && (flags[i] < key);
         eq[i]    = (CNT_W'(i) < n) && (flags[i] == key);
      end
   end

   // insertion point and exact hit
   always_comb begin
      pos     = '0;
      hit_val = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         pos = pos + CNT_W'(lt[i]);
         if (eq[i]) begin
            hit_val = hit_val | hvals[i];
         end
      end
      hit  = |eq;
      full = (n == CNT_W'(ENTRIES));
   end

   // fallback scan: highest entry at or below start that is zero or a subset
   always_comb begin
      start = (pos >= n) ? n - CNT_W'(1) : pos;
      for (int i = 0; i < ENTRIES; i++) begin
         cand[i] = (n != '0) && (CNT_W'(i) <= start) &&
                   ((flags[i] == '0) ||
                    (((flags[i] & key) != '0) && ((flags[i] & ~key) == '0)));
      end
      above[ENTRIES-1] = 1'b0;
      for (int i = ENTRIES-2; i >= 0; i--) begin
         above[i] = above[i+1] | cand[i+1];
      end
      scan_val = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (cand[i] && !above[i]) begin
            scan_val = scan_val | hvals[i];
         end
      end
      found = |cand;
   end

   // candidate rows for set-new, set-replace and unset
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (CNT_W'(i) < pos) begin
            ins_f[i] = flags[i];
            ins_h[i] = hvals[i];
         end else if (CNT_W'(i) == pos) begin
            ins_f[i] = key;
            ins_h[i] = val;
         end else if (i > 0) begin
            ins_f[i] = flags[(i > 0) ? i-1 : 0];
            ins_h[i] = hvals[(i > 0) ? i-1 : 0];
         end else begin
            ins_f[i] = flags[i];
            ins_h[i] = hvals[i];
         end
         if ((CNT_W'(i) >= pos) && (i + 1 < ENTRIES)) begin
            del_f[i] = flags[(i + 1 < ENTRIES) ? i+1 : i];
            del_h[i] = hvals[(i + 1 < ENTRIES) ? i+1 : i];
         end else begin
            del_f[i] = flags[i];
            del_h[i] = hvals[i];
         end
         rep_h[i] = eq[i] ? val : hvals[i];
      end
      row_ins[CNT_W-1:0] = n + CNT_W'(1);
      row_del[CNT_W-1:0] = n - CNT_W'(1);
      row_rep[CNT_W-1:0] = n;
      for (int i = 0; i < ENTRIES; i++) begin
         row_ins[CNT_W + i*ENTRY_W +: ENTRY_W] = {ins_f[i], ins_h[i]};
         row_del[CNT_W + i*ENTRY_W +: ENTRY_W] = {del_f[i], del_h[i]};
         row_rep[CNT_W + i*ENTRY_W +: ENTRY_W] = {flags[i], rep_h[i]};
      end
   end

   always_comb begin
      row_out    = row_rep;
      ctl.wr_en  = 1'b0;
      ctl.status = STATUS_OK;
      value_out  = '0;
      used       = n;
      if (mode == MODE_CLEAR) begin
         used = '0;
      end else if (out_of_range) begin
         ctl.status = STATUS_NOT_FOUND;
         used       = '0;
      end else begin
         case (mode)
            MODE_SET: begin
               if (hit) begin
                  ctl.wr_en = 1'b1;
               end else if (full) begin
                  ctl.status = STATUS_FULL;
               end else begin
                  row_out   = row_ins;
                  ctl.wr_en = 1'b1;
                  used      = n + CNT_W'(1);
               end
            end
            MODE_UNSET: begin
               if (hit) begin
                  row_out   = row_del;
                  ctl.wr_en = 1'b1;
                  used      = n - CNT_W'(1);
               end else begin
                  ctl.status = STATUS_NOT_FOUND;
               end
            end
            MODE_MATCH: begin
               if (hit) begin
                  value_out = hit_val;
               end else if (found) begin
                  value_out = scan_val;
               end else begin
                  ctl.status = STATUS_NOT_FOUND;
               end
            end
            default: begin
               used = '0;
            end
         endcase
      end
   end

endmodule

@@ verif/state_flag_value_table_checker.sv @@
`timescale 1ns / 100ps
module state_flag_value_table_checker
   import sfvt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [5:0]  req_property_req,
   input  logic [12:0] req_state_flags,
   input  logic [15:0] req_value_handle,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [15:0] rsp_value_out,
   input  logic [3:0]  rsp_entries_used,
   output int          mismatches,
   output int          pending
);

   typedef logic [SFVT_STATE_BITS-1:0]  flags_type;
   typedef logic [SFVT_HANDLE_BITS-1:0] handle_type;

   typedef struct packed {
      status_type status;
      handle_type value;
      logic [3:0] used;
   } lookup_word_type;

   // shadow of the table; only the first row_fill entries of a row are live
   flags_type  row_flags  [SFVT_PROPERTIES][SFVT_ENTRIES];
   handle_type row_handle [SFVT_PROPERTIES][SFVT_ENTRIES];
   int         row_fill   [SFVT_PROPERTIES];

   lookup_word_type answers[$];

   function automatic lookup_word_type table_update(mode_type mode, int row, flags_type key,
                                                    handle_type val);
      lookup_word_type ans;
      int              n;
      int              below;
      bit              hit;
      bit              found;
      int              start;
      flags_type       f;
      ans = '{status: STATUS_OK, value: '0, used: '0};
      if (mode == MODE_CLEAR) begin
         foreach (row_fill[r]) row_fill[r] = 0;
         return ans;
      end
      n     = row_fill[row];
      below = 0;
      hit   = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (row_flags[row][i] < key) below++;
         else if (row_flags[row][i] == key) hit = 1'b1;
      end
      case (mode)
         MODE_SET: begin
            if (hit) begin
               row_handle[row][below] = val;
            end else if (n >= SFVT_ENTRIES) begin
               ans.status = STATUS_FULL;
            end else begin
               for (int i = n; i > below; i--) begin
                  row_flags[row][i]  = row_flags[row][i-1];
                  row_handle[row][i] = row_handle[row][i-1];
               end
               row_flags[row][below]  = key;
               row_handle[row][below] = val;
               row_fill[row]          = n + 1;
            end
         end
         MODE_UNSET: begin
            if (hit) begin
               for (int i = below; i + 1 < n; i++) begin
                  row_flags[row][i]  = row_flags[row][i+1];
                  row_handle[row][i] = row_handle[row][i+1];
               end
               row_fill[row] = n - 1;
            end else begin
               ans.status = STATUS_NOT_FOUND;
            end
         end
         default: begin
            if (hit) begin
               ans.value = row_handle[row][below];
            end else begin
               found = 1'b0;
               if (n > 0) begin
                  // walk down from the insertion point, clamped to the last entry
                  start = (below >= n) ? n - 1 : below;
                  for (int i = start; i >= 0 && !found; i--) begin
                     f = row_flags[row][i];
                     if (f == '0 || ((f & key) != '0 && (f & ~key) == '0)) begin
                        ans.value = row_handle[row][i];
                        found     = 1'b1;
                     end
                  end
               end
               if (!found) ans.status = STATUS_NOT_FOUND;
            end
         end
      endcase
      ans.used = 4'(row_fill[row]);
      return ans;
   endfunction

   initial begin
      mismatches = 0;
      pending    = 0;
      foreach (row_fill[r]) row_fill[r] = 0;
   end

   always @(posedge clock) begin
      lookup_word_type exp_word;
      int              errs;
      errs = mismatches;
      if (!reset) begin
         // result side first: a word accepted now cannot answer a request of this edge
         if (rsp_valid && rsp_ready) begin
            if (answers.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("%0t: unexpected result word status=%0d value=%h used=%0d",
                           $realtime, rsp_status, rsp_value_out, rsp_entries_used);
            end else begin
               exp_word = answers.pop_front();
               if (rsp_status !== exp_word.status || rsp_value_out !== exp_word.value ||
                   rsp_entries_used !== exp_word.used) begin
                  errs++;
                  if (errs <= 10)
                     $display("%0t: mismatch exp %0d %h %0d got %0d %h %0d",
                              $realtime, exp_word.status, exp_word.value, exp_word.used,
                              rsp_status, rsp_value_out, rsp_entries_used);
               end
            end
         end
         if (req_valid && req_ready)
            answers.push_back(table_update(mode_type'(req_mode), int'(req_property_req),
                                           req_state_flags, req_value_handle));
      end
      mismatches <= errs;
      pending    <= answers.size();
   end

endmodule

@@ verif/state_flag_value_table_tb.sv @@
`timescale 1ns / 100ps
module state_flag_value_table_tb;
   import sfvt_pkg::*;

   // the limit is far above the slowest legal run (clears sweep 64 rows each)
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 600;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [5:0]  req_property_req;
   logic [12:0] req_state_flags;
   logic [15:0] req_value_handle;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_value_out;
   logic [3:0]  rsp_entries_used;

   int   mismatches;
   int   pending;
   int   cycles = 0;
   logic quiet  = 1'b0;   // when set, neither side inserts idle cycles

   logic [12:0] key_pool [12];
   logic [5:0]  hot_rows [4];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   state_flag_value_table i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_property_req (req_property_req),
      .req_state_flags  (req_state_flags),
      .req_value_handle (req_value_handle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_value_out    (rsp_value_out),
      .rsp_entries_used (rsp_entries_used)
   );

   state_flag_value_table_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_property_req (req_property_req),
      .req_state_flags  (req_state_flags),
      .req_value_handle (req_value_handle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_value_out    (rsp_value_out),
      .rsp_entries_used (rsp_entries_used),
      .mismatches       (mismatches),
      .pending          (pending)
   );

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // per-word idle draw, shared by both sides
   function automatic int idle_len();
      if (quiet) return 0;
      return $urandom_range(0, 13);
   endfunction

   // keys mostly from a small pool so sets, unsets and matches collide
   function automatic logic [12:0] pick_key();
      if ($urandom_range(0, 99) < 15) return 13'($urandom_range(0, 8191));
      return key_pool[$urandom_range(0, 11)];
   endfunction

   // queries are often a union of two keys, which hits the subset scan
   function automatic logic [12:0] query_key();
      if ($urandom_range(0, 1) == 0) return pick_key() | pick_key();
      return pick_key();
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with req_valid still high, so a back-to-back word never drops valid.
   task automatic send_word(input mode_type m, input logic [5:0] prop,
                            input logic [12:0] flags, input logic [15:0] handle);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode         = m;
      req_property_req = prop;
      req_state_flags  = flags;
      req_value_handle = handle;
      req_valid        = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // hold off the sender until every outstanding word has been answered
   task automatic drain();
      req_valid = 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // result side: random back-pressure per word
   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = idle_len();
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin : req_side
      int         r;
      logic [5:0] row;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_SET;
      req_property_req = '0;
      req_state_flags  = '0;
      req_value_handle = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      key_pool[0] = '0;
      for (int i = 1; i < 12; i++)
         key_pool[i] = (i < 7) ? 13'(1 << $urandom_range(0, 12))
                               : 13'($urandom_range(1, 8191) & $urandom_range(1, 8191));
      foreach (hot_rows[i]) hot_rows[i] = 6'($urandom_range(0, 63));

      // ---- directed: build up one row, then poke its corners ----
      send_word(MODE_MATCH, 6'd5, 13'h0005, 16'h0000);   // empty row -> not found
      send_word(MODE_UNSET, 6'd5, 13'h0003, 16'h0000);   // absent key
      send_word(MODE_SET,   6'd5, 13'h0000, 16'hFFFF);   // zero flags, max handle
      send_word(MODE_SET,   6'd5, 13'h1FFF, 16'h0000);   // all flags, zero handle
      send_word(MODE_SET,   6'd5, 13'h0001, 16'h1111);
      send_word(MODE_SET,   6'd5, 13'h0006, 16'h2222);
      send_word(MODE_SET,   6'd5, 13'h0004, 16'h3333);
      send_word(MODE_SET,   6'd5, 13'h0100, 16'h4444);
      send_word(MODE_SET,   6'd5, 13'h0030, 16'h5555);
      send_word(MODE_SET,   6'd5, 13'h0002, 16'h6666);   // row now holds 8 entries
      send_word(MODE_SET,   6'd5, 13'h0008, 16'h0BAD);   // new key on full row
      send_word(MODE_SET,   6'd5, 13'h0006, 16'h7777);   // replace on full row
      send_word(MODE_MATCH, 6'd5, 13'h0006, 16'h0000);   // exact hit
      send_word(MODE_MATCH, 6'd5, 13'h0005, 16'h0000);   // subset found below start
      send_word(MODE_MATCH, 6'd5, 13'h1000, 16'h0000);   // falls through to zero flags
      send_word(MODE_MATCH, 6'd5, 13'h1FFF, 16'h0000);   // exact on top entry
      send_word(MODE_MATCH, 6'd5, 13'h1FFE, 16'h0000);
      send_word(MODE_UNSET, 6'd5, 13'h1FFF, 16'h0000);
      send_word(MODE_MATCH, 6'd5, 13'h1FFF, 16'h0000);   // start clamped to last entry
      send_word(MODE_UNSET, 6'd5, 13'h0000, 16'h0000);
      send_word(MODE_MATCH, 6'd5, 13'h0800, 16'h0000);   // nothing suitable
      send_word(MODE_SET,   6'd63, 13'h1555, 16'hAAAA);
      send_word(MODE_SET,   6'd0, 13'h0AAA, 16'h5555);
      send_word(MODE_CLEAR, 6'd17, 13'h1234, 16'hBEEF);
      send_word(MODE_MATCH, 6'd63, 13'h1555, 16'h0000);  // gone after clear

      drain();

      // ---- random: mostly a few hot rows, so rows fill, overflow and drain ----
      for (int idx = 0; idx < RANDOM_WORDS; idx++) begin
         if (idx % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (idx == RANDOM_WORDS / 2) drain();
         r   = $urandom_range(0, 99);
         row = ($urandom_range(0, 4) != 0) ? hot_rows[$urandom_range(0, 3)]
                                           : 6'($urandom_range(0, 63));
         if (r < 45)
            send_word(MODE_SET, row, pick_key(), 16'($urandom_range(0, 65535)));
         else if (r < 65)
            send_word(MODE_UNSET, row, pick_key(), 16'($urandom_range(0, 65535)));
         else if (r < 98)
            send_word(MODE_MATCH, row, query_key(), 16'($urandom_range(0, 65535)));
         else
            send_word(MODE_CLEAR, 6'($urandom_range(0, 63)), 13'($urandom_range(0, 8191)),
                      16'($urandom_range(0, 65535)));
      end

      drain();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
